[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shorthand for clocked concurrent checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant");

// consequent must hold at the same edge as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// consequent must hold at the edge that follows the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

[rtl/i2cled_pkg.sv]
// ----------------------------------------------------------------------------
// i2cled_pkg
// Shared types, codes and reply text for the I2C LED command slave.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cled_pkg;

   // bus event codes
   typedef enum logic [1:0] {
      EV_ADDR_MATCH = 2'd0,
      EV_DATA       = 2'd1,
      EV_READ       = 2'd2,
      EV_OTHER      = 2'd3
   } event_type;

   // reply text selectors
   localparam logic [2:0] SEL_EMPTY    = 3'd0;
   localparam logic [2:0] SEL_ON_BASE  = 3'd1;
   localparam logic [2:0] SEL_OFF_BASE = 3'd4;
   localparam logic [2:0] SEL_ERROR    = 3'd7;

   // reply window and pointer limits
   localparam logic [4:0] REPLY_LENGTH = 5'd10;
   localparam logic [3:0] PTR_MAX      = 4'hF;

   // command characters
   localparam logic [7:0] CHAR_SET   = 8'h73;  // 's'
   localparam logic [7:0] CHAR_RESET = 8'h72;  // 'r'
   localparam logic [7:0] CHAR_ONE   = 8'h31;  // '1'
   localparam logic [7:0] CHAR_TWO   = 8'h32;  // '2'
   localparam logic [7:0] CHAR_THREE = 8'h33;  // '3'

   typedef struct packed {
      event_type  ev;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic       bad_command;
      logic       executed;
      logic [2:0] led_bits;
      logic [7:0] tx_byte;
   } result_type;

   // "LED-n-ON", "LED-n-OFF", "--ERROR--", all zero past the text
   function automatic logic [7:0] reply_char(input logic [2:0] sel, input logic [3:0] idx);
      logic [7:0] digit;
      logic [7:0] ch;
      logic       is_off;
      digit  = 8'h30;
      ch     = 8'h00;
      is_off = (sel >= SEL_OFF_BASE);
      if (sel == SEL_EMPTY) begin
         ch = 8'h00;
      end else if (sel == SEL_ERROR) begin
         case (idx)
            4'd0, 4'd1, 4'd7, 4'd8: ch = 8'h2D;  // '-'
            4'd2:    ch = 8'h45;                 // 'E'
            4'd3:    ch = 8'h52;                 // 'R'
            4'd4:    ch = 8'h52;
            4'd5:    ch = 8'h4F;                 // 'O'
            4'd6:    ch = 8'h52;
            default: ch = 8'h00;
         endcase
      end else begin
         if (is_off) digit = 8'h31 + {5'd0, sel - SEL_OFF_BASE};
         else        digit = 8'h31 + {5'd0, sel - SEL_ON_BASE};
         case (idx)
            4'd0:    ch = 8'h4C;                 // 'L'
            4'd1:    ch = 8'h45;                 // 'E'
            4'd2:    ch = 8'h44;                 // 'D'
            4'd3:    ch = 8'h2D;
            4'd4:    ch = digit;
            4'd5:    ch = 8'h2D;
            4'd6:    ch = 8'h4F;                 // 'O'
            4'd7:    ch = is_off ? 8'h46 : 8'h4E; // 'F' or 'N'
            4'd8:    ch = is_off ? 8'h46 : 8'h00;
            default: ch = 8'h00;
         endcase
      end
      return ch;
   endfunction

endpackage

[rtl/i2cled_core.sv]
// ----------------------------------------------------------------------------
// i2cled_core
// Command state and single-pass event decode. Result is combinational from
// the current item and state; state advances when step is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cled_core
   import i2cled_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   output result_type result
);

   logic       have_first_ff, have_first_in;
   logic [7:0] first_byte_ff, first_byte_in;
   logic [2:0] led_ff, led_in;
   logic [2:0] reply_sel_ff, reply_sel_in;
   logic [3:0] reply_ptr_ff, reply_ptr_in;

   logic [1:0] led_idx;
   logic       led_hit;
   logic [2:0] led_mask;

   always_comb begin
      led_hit = 1'b1;
      led_idx = 2'd0;
      case (item.data_byte)
         CHAR_ONE:   led_idx = 2'd0;
         CHAR_TWO:   led_idx = 2'd1;
         CHAR_THREE: led_idx = 2'd2;
         default:    led_hit = 1'b0;
      endcase
      led_mask = 3'b001 << led_idx;
   end

   always_comb begin
      have_first_in = have_first_ff;
      first_byte_in = first_byte_ff;
      led_in        = led_ff;
      reply_sel_in  = reply_sel_ff;
      reply_ptr_in  = reply_ptr_ff;
      result        = '0;

      unique case (item.ev)
         EV_ADDR_MATCH: begin
            have_first_in = 1'b0;
         end
         EV_DATA: begin
            if (!have_first_ff) begin
               first_byte_in = item.data_byte;
               have_first_in = 1'b1;
            end else begin
               if (led_hit && first_byte_ff == CHAR_SET) begin
                  led_in       = led_ff | led_mask;
                  reply_sel_in = SEL_ON_BASE + {1'b0, led_idx};
               end else if (led_hit && first_byte_ff == CHAR_RESET) begin
                  led_in       = led_ff & ~led_mask;
                  reply_sel_in = SEL_OFF_BASE + {1'b0, led_idx};
               end else begin
                  reply_sel_in       = SEL_ERROR;
                  result.bad_command = 1'b1;
               end
               result.executed = 1'b1;
               have_first_in   = 1'b0;
               reply_ptr_in    = '0;
            end
         end
         EV_READ: begin
            if ({1'b0, reply_ptr_ff} < REPLY_LENGTH) begin
               result.tx_byte = reply_char(reply_sel_ff, reply_ptr_ff);
               if (reply_ptr_ff != PTR_MAX) reply_ptr_in = reply_ptr_ff + 4'd1;
            end
         end
         EV_OTHER: begin
         end
         default: begin
         end
      endcase

      result.led_bits = led_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_first_ff <= 1'b0;
         first_byte_ff <= '0;
         led_ff        <= '0;
         reply_sel_ff  <= SEL_EMPTY;
         reply_ptr_ff  <= '0;
      end else if (step) begin
         have_first_ff <= have_first_in;
         first_byte_ff <= first_byte_in;
         led_ff        <= led_in;
         reply_sel_ff  <= reply_sel_in;
         reply_ptr_ff  <= reply_ptr_in;
      end
   end

endmodule

[rtl/i2c_led_command_slave.sv]
// ----------------------------------------------------------------------------
// i2c_led_command_slave
// LED command interpreter behind I2C address match: one bus event in, one
// result out, with reply text returned on read events.
// ----------------------------------------------------------------------------
//  channel   dir   tuser          tdata
//  req_      in    [1:0] event    [7:0] data_byte
//  rsp_      out   -              [7:0] tx_byte, [10:8] led_bits,
//                                 [11] executed, [12] bad_command
//
//  One transaction per clock sustained while rsp_tready holds high. Items pass
//  through the input register, then the result register; decode and the reply
//  text lookup sit between them. Synchronous active-high reset clears command
//  state, LEDs and reply select. A stalled result holds the result register;
//  one more item waits in the input register before req_tready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module i2c_led_command_slave
   import i2cled_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [15:8] zero
   input  logic [1:0]  req_tuser,   // [1:0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [7:0] tx_byte, [10:8] led_bits,
                                    // [11] executed, [12] bad_command, [15:13] zero
);

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_result_ff;
   result_type result;
   logic       req_fire;
   logic       advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;

      out_valid_in = out_valid_ff;
      if (advance)         out_valid_in = 1'b1;
      else if (rsp_tready) out_valid_in = 1'b0;
   end

   i2cled_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.ev        <= event_type'(req_tuser);
         in_item_ff.data_byte <= req_tdata[7:0];
      end
      if (advance) out_result_ff <= result;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_result_ff};

   `ASSERT_IMPLY(a_bad_needs_exec, clock, reset,
      out_valid_ff && out_result_ff.bad_command, out_result_ff.executed)
   `ASSERT_NEXT(a_held_item_kept, clock, reset,
      in_valid_ff && !advance, in_valid_ff)
   `ASSERT_NEXT(a_result_held, clock, reset,
      out_valid_ff && !rsp_tready, out_valid_ff && $stable(out_result_ff))

endmodule

[tb/i2c_led_command_slave_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_led_command_slave_tb
// Self-checking bench for the I2C LED command slave. A directed table covers
// reset state, stop events, stray data bytes, reads past the reply text and
// bad commands. Random command sequences with random reads and noise follow.
// Every response is compared field by field against an in-bench model or a typed
// value, with random gaps and stalls on both streams and long response hold-offs.
// ----------------------------------------------------------------------------
module i2c_led_command_slave_tb;
   import i2cled_pkg::*;

   localparam int STIM_ITEMS  = 1400;
   localparam int STALL_LIMIT = 1000;
   localparam int HOLD_CYCLES = 80;

   typedef struct {
      event_type  ev;
      logic [7:0] data_byte;
      bit         exact;
      result_type typed;
   } stim_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;

   // travels with the offered transaction: use the typed-in value, not the model
   bit         req_exact = 1'b0;
   result_type req_typed = '0;

   stim_row_type stim_rows[$];
   result_type   pending_responses[$];
   int           error_count  = 0;
   int           stall_cycles = 0;

   // command interpreter model state
   logic [1:0] cmd_byte_count = '0;
   logic [7:0] cmd_first_char = '0;
   logic [2:0] led_state      = '0;
   logic [2:0] reply_sel      = SEL_EMPTY;
   logic [3:0] reply_pos      = '0;

   always #6 clock = ~clock;

   i2c_led_command_slave i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   function automatic result_type make_result(input logic [7:0] tx, input logic [2:0] leds,
                                              input logic exec, input logic bad);
      result_type r;
      r.tx_byte     = tx;
      r.led_bits    = leds;
      r.executed    = exec;
      r.bad_command = bad;
      return r;
   endfunction

   function automatic logic [7:0] reply_char_at(input logic [2:0] sel, input logic [3:0] pos);
      string text;
      text = "";
      if (sel == SEL_ERROR)
         text = "--ERROR--";
      else if (sel >= SEL_OFF_BASE)
         text = $sformatf("LED-%0d-OFF", sel - SEL_OFF_BASE + 3'd1);
      else if (sel >= SEL_ON_BASE)
         text = $sformatf("LED-%0d-ON", sel - SEL_ON_BASE + 3'd1);
      if (pos < text.len())
         return text[pos];
      return 8'h00;
   endfunction

   // advances the model by one bus event and returns the response it gives
   function result_type predict_led_response(input event_type ev, input logic [7:0] data_byte);
      result_type r;
      logic [1:0] led_idx;
      bit         led_ok;
      r       = '0;
      led_idx = '0;
      led_ok  = 1'b1;
      case (ev)
         EV_ADDR_MATCH: cmd_byte_count = '0;
         EV_DATA: begin
            if (cmd_byte_count == 2'd0) begin
               cmd_first_char = data_byte;
               cmd_byte_count = 2'd1;
            end else begin
               case (data_byte)
                  CHAR_ONE:   led_idx = 2'd0;
                  CHAR_TWO:   led_idx = 2'd1;
                  CHAR_THREE: led_idx = 2'd2;
                  default:    led_ok  = 1'b0;
               endcase
               if (led_ok && cmd_first_char == CHAR_SET) begin
                  led_state[led_idx] = 1'b1;
                  reply_sel          = SEL_ON_BASE + {1'b0, led_idx};
               end else if (led_ok && cmd_first_char == CHAR_RESET) begin
                  led_state[led_idx] = 1'b0;
                  reply_sel          = SEL_OFF_BASE + {1'b0, led_idx};
               end else begin
                  reply_sel     = SEL_ERROR;
                  r.bad_command = 1'b1;
               end
               r.executed     = 1'b1;
               cmd_byte_count = '0;
               reply_pos      = '0;
            end
         end
         EV_READ: begin
            if (reply_pos < REPLY_LENGTH) begin
               r.tx_byte = reply_char_at(reply_sel, reply_pos);
               if (reply_pos != PTR_MAX)
                  reply_pos = reply_pos + 4'd1;
            end
         end
         default: ;
      endcase
      r.led_bits = led_state;
      return r;
   endfunction

   function void check_field(input string name, input logic [7:0] exp, input logic [7:0] act);
      if (exp !== act) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp, act);
      end
   endfunction

   task add_row(input event_type ev, input logic [7:0] data_byte, input bit exact,
                input result_type typed);
      stim_row_type row;
      row.ev        = ev;
      row.data_byte = data_byte;
      row.exact     = exact;
      row.typed     = typed;
      stim_rows.push_back(row);
   endtask

   // scoreboard: model on accepted requests, compare on accepted responses
   always @(posedge clock) begin
      result_type predicted;
      result_type expected;
      result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predicted = predict_led_response(event_type'(req_tuser), req_tdata[7:0]);
            pending_responses.push_back(req_exact ? req_typed : predicted);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[12:0]);
            if (pending_responses.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response, expected none, actual %h", $time, rsp_tdata);
            end else begin
               expected = pending_responses.pop_front();
               check_field("tx_byte", expected.tx_byte, got.tx_byte);
               check_field("led_bits", {5'd0, expected.led_bits}, {5'd0, got.led_bits});
               check_field("executed", {7'd0, expected.executed}, {7'd0, got.executed});
               check_field("bad_command", {7'd0, expected.bad_command},
                           {7'd0, got.bad_command});
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles == STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // response side: random stalls, quiet stretches, two long hold-offs
   initial begin
      int wait_cycles;
      int rsp_count;
      rsp_count = 0;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_count == 30 || rsp_count == 800)
            wait_cycles = HOLD_CYCLES;
         else if ((rsp_count / 64) % 4 == 3)
            wait_cycles = 0;
         else
            wait_cycles = $urandom_range(0, 9);
         if (wait_cycles > 0) begin
            rsp_tready <= 1'b0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         rsp_count++;
      end
   end

   initial begin
      stim_row_type row;
      int           gap;
      logic [7:0]   pick_char;

      // reads before any command, stop event, data without address match
      add_row(EV_READ,  8'h00,      1, make_result(8'h00, 3'd0, 1'b0, 1'b0));
      add_row(EV_OTHER, 8'hFF,      1, make_result(8'h00, 3'd0, 1'b0, 1'b0));
      add_row(EV_DATA,  CHAR_SET,   1, make_result(8'h00, 3'd0, 1'b0, 1'b0));
      add_row(EV_DATA,  CHAR_ONE,   1, make_result(8'h00, 3'd1, 1'b1, 1'b0));
      add_row(EV_READ,  8'hFF,      1, make_result(8'h4C, 3'd1, 1'b0, 1'b0)); // 'L'
      // rest of the text, then zeros up to and past the reply window
      repeat (10) add_row(EV_READ, 8'h00, 0, '0);
      // address match in the middle of a command restarts it
      add_row(EV_ADDR_MATCH, 8'hFF, 0, '0);
      add_row(EV_DATA, CHAR_RESET,  0, '0);
      add_row(EV_ADDR_MATCH, 8'h00, 0, '0);
      add_row(EV_DATA, CHAR_SET,    0, '0);
      add_row(EV_DATA, CHAR_THREE,  0, '0);
      // unrecognized command leaves the LEDs alone
      add_row(EV_ADDR_MATCH, 8'h00, 0, '0);
      add_row(EV_DATA, 8'hFF,       0, '0);
      add_row(EV_DATA, 8'h00,       1, make_result(8'h00, 3'd5, 1'b1, 1'b1));
      add_row(EV_READ, 8'h00,       0, '0);
      add_row(EV_DATA, CHAR_RESET,  0, '0);
      add_row(EV_DATA, CHAR_ONE,    0, '0);
      add_row(EV_READ, 8'hFF,       0, '0);

      // mostly well-formed commands with reads, some broken ones and noise
      while (stim_rows.size() < STIM_ITEMS) begin
         if ($urandom_range(0, 9) < 8) begin
            if ($urandom_range(0, 9) != 0)
               add_row(EV_ADDR_MATCH, 8'($urandom), 0, '0);
            case ($urandom_range(0, 4))
               0, 1:    pick_char = CHAR_SET;
               2, 3:    pick_char = CHAR_RESET;
               default: pick_char = 8'($urandom);
            endcase
            add_row(EV_DATA, pick_char, 0, '0);
            if ($urandom_range(0, 15) == 0)
               add_row(EV_ADDR_MATCH, 8'($urandom), 0, '0);
            case ($urandom_range(0, 4))
               0:       pick_char = CHAR_ONE;
               1:       pick_char = CHAR_TWO;
               2:       pick_char = CHAR_THREE;
               default: pick_char = 8'($urandom);
            endcase
            add_row(EV_DATA, pick_char, 0, '0);
            repeat ($urandom_range(0, 12)) add_row(EV_READ, 8'($urandom), 0, '0);
            if ($urandom_range(0, 3) == 0)
               add_row(EV_OTHER, 8'($urandom), 0, '0);
         end else begin
            repeat ($urandom_range(1, 4))
               add_row(event_type'($urandom_range(0, 3)), 8'($urandom), 0, '0);
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (int n = 0; n < stim_rows.size(); n++) begin
         row = stim_rows[n];
         gap = ((n / 64) % 4 == 2) ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tuser  <= row.ev;
         req_tdata  <= {8'h00, row.data_byte};
         req_exact  <= row.exact;
         req_typed  <= row.typed;
         do @(posedge clock); while (!req_tready);
      end
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
